// ===== sv/iqted_pkg.sv =====
// Shared types, register indexes and reset values for the IQ tone energy detector.
`default_nettype none

package iqted_pkg;

  // Default accumulator width of the in-phase and quadrature sums.
  localparam int ACC_WIDTH_DEF = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_GROUPS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGNITUDE_SHIFT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_KIND       = 2'd3;

  // Register reset values.
  localparam logic [15:0] WINDOW_GROUPS_RST    = 16'd16;
  localparam logic [4:0]  MAGNITUDE_SHIFT_RST  = 5'd4;
  localparam logic [30:0] ENERGY_THRESHOLD_RST = 31'd1000000;
  localparam logic [3:0]  EVENT_KIND_RST       = 4'd1;

  typedef struct packed {
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic               last_group;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] event_index;
    logic [3:0]  event_code;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/iq_tone_energy_detector.sv =====
// Top level of the quarter-rate IQ tone energy detector.
//
// Each input beat on in_data carries one group of four signed samples. The
// group is mixed with a tone at a quarter of the sample rate: the in-phase sum
// gains sample_0 - sample_2 and the quadrature sum gains sample_1 - sample_3.
// When the configured number of groups has been summed, both sums are shifted
// right, their squared magnitude is compared with the threshold, and if it is
// greater, out_data reports the closing group's start index and the event kind.
// A group flagged last_group closes the run: the sums, the group count and
// the sample index return to zero after it has been processed.
// One group is accepted every cycle while in_ready is high. The sums update at
// acceptance; a window check runs through four register stages in order
// (capture, shift and magnitude, squares, compare) before any event is shown.
// Every stage holds its beat only while the one after it is full, so a
// stalled receiver costs no input cycles until the stages have filled.
// Configuration must be written through cfg_we, cfg_index and cfg_wdata only
// while no window check is in flight; the block does not enforce it.
// Synchronous reset clears sums, counters and valid flags and resets config.
`default_nettype none

module iq_tone_energy_detector
  import iqted_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_beat_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_beat_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SHW = $clog2(ACC_WIDTH);

  // Configuration registers.
  logic [15:0] window_groups_r;
  logic [4:0]  magnitude_shift_r;
  logic [30:0] energy_threshold_r;
  logic [3:0]  event_kind_r;

  // Run state.
  logic signed [ACC_WIDTH-1:0] i_sum_r, i_sum_nxt;
  logic signed [ACC_WIDTH-1:0] q_sum_r, q_sum_nxt;
  logic [15:0] group_count_r, group_count_nxt;
  logic [31:0] position_r, position_nxt;

  // Window check stages.
  logic                 s1_v_r;
  logic [ACC_WIDTH-1:0] s1_i_r, s1_q_r;
  logic [31:0]          s1_idx_r;
  logic                 s2_v_r, s2_big_r;
  logic [15:0]          s2_mi_r, s2_mq_r;
  logic [31:0]          s2_idx_r;
  logic                 s3_v_r, s3_big_r;
  logic [31:0]          s3_ii_r, s3_qq_r;
  logic [31:0]          s3_idx_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;

  logic               in_fire;
  logic               close_win;
  logic signed [16:0] i_diff, q_diff;
  logic [ACC_WIDTH-1:0] i_upd, q_upd;
  logic [15:0]        count_upd;
  logic               rdy_o, rdy3, rdy2, rdy1;
  logic [SHW-1:0]     sh_amt;
  logic [ACC_WIDTH:0] mag_i, mag_q;
  logic               hit;
  logic [32:0]        energy;

  // Absolute value of an arithmetically shifted sum, one bit wider than the sum.
  function automatic logic [ACC_WIDTH:0] shifted_mag(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic [SHW-1:0] sh);
    logic signed [ACC_WIDTH-1:0] sv;
    logic [ACC_WIDTH:0]          ext;
    sv  = $signed(acc) >>> sh;
    ext = {sv[ACC_WIDTH-1], sv};
    if (sv[ACC_WIDTH-1]) begin
      return (ACC_WIDTH+1)'(0) - ext;
    end
    return ext;
  endfunction

  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !s3_v_r || rdy_o;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;
  assign in_fire  = in_valid && rdy1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Accumulation of one group.
  always_comb begin
    i_diff    = 17'(in_data.sample_0) - 17'(in_data.sample_2);
    q_diff    = 17'(in_data.sample_1) - 17'(in_data.sample_3);
    i_upd     = i_sum_r + ACC_WIDTH'(i_diff);
    q_upd     = q_sum_r + ACC_WIDTH'(q_diff);
    count_upd = group_count_r + 16'd1;
    close_win = (count_upd == window_groups_r);

    i_sum_nxt       = i_sum_r;
    q_sum_nxt       = q_sum_r;
    group_count_nxt = group_count_r;
    position_nxt    = position_r;
    if (in_fire) begin
      position_nxt = position_r + 32'd4;
      if (close_win) begin
        i_sum_nxt       = '0;
        q_sum_nxt       = '0;
        group_count_nxt = '0;
      end else begin
        i_sum_nxt       = i_upd;
        q_sum_nxt       = q_upd;
        group_count_nxt = count_upd;
      end
      if (in_data.last_group) begin
        i_sum_nxt       = '0;
        q_sum_nxt       = '0;
        group_count_nxt = '0;
        position_nxt    = '0;
      end
    end
  end

  // Shifts of the sum width or more leave only sign bits.
  always_comb begin
    if (int'(magnitude_shift_r) > ACC_WIDTH - 1) begin
      sh_amt = SHW'(ACC_WIDTH - 1);
    end else begin
      sh_amt = SHW'(magnitude_shift_r);
    end
    mag_i = shifted_mag(s1_i_r, sh_amt);
    mag_q = shifted_mag(s1_q_r, sh_amt);
  end

  assign energy = {1'b0, s3_ii_r} + {1'b0, s3_qq_r};
  // A magnitude of 2^16 or more squares above any threshold.
  assign hit    = s3_big_r || (energy > {2'b00, energy_threshold_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_groups_r    <= WINDOW_GROUPS_RST;
      magnitude_shift_r  <= MAGNITUDE_SHIFT_RST;
      energy_threshold_r <= ENERGY_THRESHOLD_RST;
      event_kind_r       <= EVENT_KIND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_GROUPS:    window_groups_r    <= cfg_wdata[15:0];
        CFG_MAGNITUDE_SHIFT:  magnitude_shift_r  <= cfg_wdata[4:0];
        CFG_ENERGY_THRESHOLD: energy_threshold_r <= cfg_wdata[30:0];
        CFG_EVENT_KIND:       event_kind_r       <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_sum_r       <= '0;
      q_sum_r       <= '0;
      group_count_r <= '0;
      position_r    <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      i_sum_r       <= i_sum_nxt;
      q_sum_r       <= q_sum_nxt;
      group_count_r <= group_count_nxt;
      position_r    <= position_nxt;
      if (rdy1) begin
        s1_v_r <= in_fire && close_win;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy_o) begin
        out_valid_r <= s3_v_r && hit;
      end
    end
  end

  // Stage payloads carry no reset.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_i_r   <= i_upd;
      s1_q_r   <= q_upd;
      s1_idx_r <= position_r;
    end
    if (rdy2) begin
      s2_big_r <= (|mag_i[ACC_WIDTH:16]) || (|mag_q[ACC_WIDTH:16]);
      s2_mi_r  <= mag_i[15:0];
      s2_mq_r  <= mag_q[15:0];
      s2_idx_r <= s1_idx_r;
    end
    if (rdy3) begin
      s3_big_r <= s2_big_r;
      s3_ii_r  <= 32'(s2_mi_r) * 32'(s2_mi_r);
      s3_qq_r  <= 32'(s2_mq_r) * 32'(s2_mq_r);
      s3_idx_r <= s2_idx_r;
    end
    if (rdy_o) begin
      out_data_r.event_index <= s3_idx_r;
      out_data_r.event_code  <= event_kind_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/iqted_checker.sv =====
// Port-level checks for the IQ tone energy detector, bound to its top level.
`default_nettype none

module iqted_checker
  import iqted_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  // A result beat that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // Groups start on multiples of four samples.
  a_index_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_index[1:0] == 2'b00)
    else $error("event index not aligned to a group");

  // Leaving reset, the pipeline is empty and ready for a group.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // While the result register is free, the input side is never held off.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

bind iq_tone_energy_detector iqted_checker u_iqted_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/iq_tone_energy_detector_tb.sv =====
// Self-checking testbench for the quarter-rate IQ tone energy detector.
module iq_tone_energy_detector_tb;
  import iqted_pkg::*;

  localparam int ACC_W       = ACC_WIDTH_DEF;
  localparam int PIPE_DRAIN  = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_GROUPS = 1500;

  typedef enum int {STYLE_TONE, STYLE_CORNER, STYLE_NOISE, STYLE_SATURATE} group_style_e;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    in_beat_t               grp;
    bit                     typed;
    bit                     hit;
    out_beat_t              ev;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_beat_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_beat_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  iq_tone_energy_detector #(.ACC_WIDTH(ACC_W)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Detector state as the block should hold it.
  logic signed [ACC_W-1:0] acc_i;
  logic signed [ACC_W-1:0] acc_q;
  logic [15:0]             groups_seen;
  logic [31:0]             next_index;
  logic [15:0]             win_groups;
  logic [4:0]              mag_shift;
  logic [30:0]             energy_thr;
  logic [3:0]              kind_cfg;

  out_beat_t pending_events[$];
  out_beat_t predicted_event;
  out_beat_t wanted;
  bit        predicted_hit;

  // Hand-written expectation for the beat currently on offer, if any.
  bit        row_typed;
  bit        row_hit;
  out_beat_t row_ev;

  int groups_accepted;
  int events_checked;
  int settings_applied;
  int mismatches;
  int idle_cycles;

  int burst_left;
  bit gappy;
  int tone_i;
  int tone_q;
  int noise_span;

  plan_row_t plan[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function void clear_state();
    acc_i       = '0;
    acc_q       = '0;
    groups_seen = '0;
    next_index  = '0;
  endfunction

  function automatic bit detect_tone(input in_beat_t g, output out_beat_t ev);
    int                      sh;
    longint                  mi;
    longint                  mq;
    logic signed [ACC_W-1:0] si;
    logic signed [ACC_W-1:0] sq;
    bit                      hit;
    hit = 1'b0;
    ev  = '0;
    acc_i = acc_i + $signed(g.sample_0) - $signed(g.sample_2);
    acc_q = acc_q + $signed(g.sample_1) - $signed(g.sample_3);
    groups_seen = groups_seen + 16'd1;
    if (groups_seen == win_groups) begin
      // Shifts past the sum width saturate to pure sign bits.
      sh = (int'(mag_shift) > ACC_W - 1) ? ACC_W - 1 : int'(mag_shift);
      si = acc_i >>> sh;
      sq = acc_q >>> sh;
      mi = si;
      mq = sq;
      if (mi < 0) mi = -mi;
      if (mq < 0) mq = -mq;
      hit = (mi >= 65536) || (mq >= 65536) || (mi * mi + mq * mq > longint'(energy_thr));
      ev.event_index = next_index;
      ev.event_code  = kind_cfg;
      acc_i       = '0;
      acc_q       = '0;
      groups_seen = '0;
    end
    next_index = next_index + 32'd4;
    if (g.last_group) clear_state();
    return hit;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] corner_sample();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic in_beat_t random_group(input group_style_e style, input bit last);
    in_beat_t g;
    int       n0;
    int       n1;
    int       n2;
    int       n3;
    n0 = int'($urandom_range(0, 2 * noise_span)) - noise_span;
    n1 = int'($urandom_range(0, 2 * noise_span)) - noise_span;
    n2 = int'($urandom_range(0, 2 * noise_span)) - noise_span;
    n3 = int'($urandom_range(0, 2 * noise_span)) - noise_span;
    case (style)
      STYLE_TONE: begin
        g.sample_0 = clip16(tone_i + n0);
        g.sample_1 = clip16(tone_q + n1);
        g.sample_2 = clip16(-tone_i + n2);
        g.sample_3 = clip16(-tone_q + n3);
      end
      STYLE_CORNER: begin
        g.sample_0 = corner_sample();
        g.sample_1 = corner_sample();
        g.sample_2 = corner_sample();
        g.sample_3 = corner_sample();
      end
      STYLE_SATURATE: begin
        g.sample_0 = 16'sd32767;
        g.sample_1 = 16'($urandom);
        g.sample_2 = -16'sd32768;
        g.sample_3 = 16'($urandom);
      end
      default: begin
        g.sample_0 = 16'($urandom);
        g.sample_1 = 16'($urandom);
        g.sample_2 = 16'($urandom);
        g.sample_3 = 16'($urandom);
      end
    endcase
    g.last_group = last;
    return g;
  endfunction

  function automatic plan_row_t group_row(input int s0, input int s1, input int s2,
                                          input int s3, input bit last, input bit typed,
                                          input bit hit, input logic [31:0] idx,
                                          input logic [3:0] code);
    plan_row_t r;
    r.is_cfg         = 1'b0;
    r.reg_index      = '0;
    r.reg_value      = '0;
    r.grp.sample_0   = 16'(s0);
    r.grp.sample_1   = 16'(s1);
    r.grp.sample_2   = 16'(s2);
    r.grp.sample_3   = 16'(s3);
    r.grp.last_group = last;
    r.typed          = typed;
    r.hit            = hit;
    r.ev.event_index = idx;
    r.ev.event_code  = code;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r           = group_row(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, '0, '0);
    r.is_cfg    = 1'b1;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  task automatic send_group(input in_beat_t g, input bit typed, input bit hit,
                            input out_beat_t ev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = gappy ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_data   <= g;
    row_typed = typed;
    row_hit   = hit;
    row_ev    = ev;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every expected event arrive, then give windows that raise no event
  // time to leave the pipeline before the registers are touched.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WINDOW_GROUPS:    win_groups = val[15:0];
      CFG_MAGNITUDE_SHIFT:  mag_shift  = val[4:0];
      CFG_ENERGY_THRESHOLD: energy_thr = val[30:0];
      CFG_EVENT_KIND:       kind_cfg   = val[3:0];
      default: ;
    endcase
    settings_applied++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] win, input logic [4:0] sh,
                                input logic [30:0] thr, input logic [3:0] kind);
    settle();
    write_reg(CFG_WINDOW_GROUPS, 31'(win));
    write_reg(CFG_MAGNITUDE_SHIFT, 31'(sh));
    write_reg(CFG_ENERGY_THRESHOLD, thr);
    write_reg(CFG_EVENT_KIND, 31'(kind));
  endtask

  // Results are checked before the accepted group is predicted, so the two
  // never race within one edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        events_checked++;
        if (pending_events.size() == 0) begin
          mismatches++;
          $display("%0t: event beat with none pending: expected none, got index %h code %h",
                   $time, out_data.event_index, out_data.event_code);
        end else begin
          wanted = pending_events.pop_front();
          if (out_data.event_index !== wanted.event_index) begin
            mismatches++;
            $display("%0t: event_index expected %h got %h",
                     $time, wanted.event_index, out_data.event_index);
          end
          if (out_data.event_code !== wanted.event_code) begin
            mismatches++;
            $display("%0t: event_code expected %h got %h",
                     $time, wanted.event_code, out_data.event_code);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted_hit = detect_tone(in_data, predicted_event);
        if (row_typed) begin
          predicted_hit   = row_hit;
          predicted_event = row_ev;
        end
        if (predicted_hit) pending_events.push_back(predicted_event);
        groups_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d events still pending",
                   $time, idle_cycles, pending_events.size());
          $display("iq_tone_energy_detector: mismatch");
          $finish;
        end
      end
    end
  end

  // Receiver: alternates between always ready, coin-flip, periodic stalls and
  // rare long stalls, each for a random span of cycles.
  initial begin
    int mode;
    int span;
    int period;
    int stall_len;
    int stall_left;
    int k;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      mode      = $urandom_range(0, 3);
      span      = $urandom_range(64, 256);
      period    = $urandom_range(2, 9);
      stall_len = $urandom_range(1, period - 1);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % period) >= stall_len;
          default: begin
            if (stall_left > 0) begin
              out_ready <= 1'b0;
              stall_left--;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 24);
            end
          end
        endcase
      end
    end
  end

  initial begin
    int           k;
    int           j;
    int           len;
    int           random_groups;
    int           pick;
    bit           busy;
    bit           last;
    group_style_e style;
    logic [15:0]  win;
    logic [4:0]   sh;
    logic [30:0]  thr;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    row_typed = 1'b0;
    row_hit   = 1'b0;
    row_ev    = '0;
    groups_accepted  = 0;
    events_checked   = 0;
    settings_applied = 0;
    mismatches       = 0;
    idle_cycles      = 0;
    burst_left       = 0;
    gappy            = 1'b1;
    tone_i           = 0;
    tone_q           = 0;
    noise_span       = 0;
    random_groups    = 0;
    busy             = 1'b0;

    win_groups = WINDOW_GROUPS_RST;
    mag_shift  = MAGNITUDE_SHIFT_RST;
    energy_thr = ENERGY_THRESHOLD_RST;
    kind_cfg   = EVENT_KIND_RST;
    clear_state();

    // Reset settings: sixteen full-scale groups build I = 16 * 65535 and
    // Q = -16 * 65535, which shift down to magnitude 65535 each.
    for (k = 0; k < 15; k++)
      plan.push_back(group_row(32767, -32768, -32768, 32767, 1'b0, 1'b1, 1'b0, '0, '0));
    plan.push_back(group_row(32767, -32768, -32768, 32767, 1'b0, 1'b1, 1'b1, 32'd60, 4'd1));
    // Widest shift leaves only sign bits; a zero threshold still needs energy above it.
    plan.push_back(cfg_row(CFG_WINDOW_GROUPS, 31'd1));
    plan.push_back(cfg_row(CFG_MAGNITUDE_SHIFT, 31'd31));
    plan.push_back(cfg_row(CFG_ENERGY_THRESHOLD, 31'd0));
    plan.push_back(cfg_row(CFG_EVENT_KIND, 31'd15));
    plan.push_back(group_row(-32768, 0, 32767, 0, 1'b0, 1'b1, 1'b1, 32'd64, 4'd15));
    plan.push_back(group_row(0, 0, 0, 0, 1'b0, 1'b1, 1'b0, '0, '0));
    plan.push_back(group_row(0, 32767, 0, 0, 1'b1, 1'b1, 1'b0, '0, '0));
    // No shift and the largest threshold: these two groups reach a magnitude over 2^16.
    plan.push_back(cfg_row(CFG_MAGNITUDE_SHIFT, 31'd0));
    plan.push_back(cfg_row(CFG_ENERGY_THRESHOLD, 31'h7FFFFFFF));
    plan.push_back(cfg_row(CFG_WINDOW_GROUPS, 31'd2));
    plan.push_back(cfg_row(CFG_EVENT_KIND, 31'd0));
    plan.push_back(group_row(32767, 32767, -32768, -32768, 1'b0, 1'b1, 1'b0, '0, '0));
    plan.push_back(group_row(32767, 32767, -32768, -32768, 1'b0, 1'b1, 1'b1, 32'd4, 4'd0));
    plan.push_back(group_row(100, 0, 0, 0, 1'b0, 1'b1, 1'b0, '0, '0));
    // The closing group of a run may still raise its event.
    plan.push_back(group_row(0, -32768, 0, 32767, 1'b1, 1'b0, 1'b0, '0, '0));
    plan.push_back(cfg_row(CFG_WINDOW_GROUPS, 31'd1));
    plan.push_back(cfg_row(CFG_MAGNITUDE_SHIFT, 31'd2));
    plan.push_back(cfg_row(CFG_ENERGY_THRESHOLD, 31'd1000));
    plan.push_back(cfg_row(CFG_EVENT_KIND, 31'd9));
    plan.push_back(group_row(1234, -999, -4321, 77, 1'b0, 1'b0, 1'b0, '0, '0));
    plan.push_back(group_row(-20000, 5, 20000, -6, 1'b1, 1'b0, 1'b0, '0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(plan[k].reg_index, plan[k].reg_value);
      end else begin
        busy = 1'b1;
        send_group(plan[k].grp, plan[k].typed, plan[k].hit, plan[k].ev);
      end
    end

    // Random runs: mostly coherent tones so windows build up energy, with
    // corner values, full-scale groups and raw noise mixed in. Each run ends
    // on a closing group.
    while (random_groups < RANDOM_GROUPS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) win = 16'($urandom_range(1, 4));
      else if (pick < 9) win = 16'($urandom_range(5, 40));
      else win = 16'($urandom_range(41, 300));
      sh = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(11, 31)) : 5'($urandom_range(0, 10));
      thr = 31'($urandom) & 31'((64'd1 << $urandom_range(0, 31)) - 64'd1);
      apply_settings(win, sh, thr, 4'($urandom));
      gappy      = $urandom_range(0, 3) != 0;
      tone_i     = (int'($urandom_range(0, 32767)) >> $urandom_range(0, 14));
      tone_q     = (int'($urandom_range(0, 32767)) >> $urandom_range(0, 14));
      if ($urandom_range(0, 1)) tone_i = -tone_i;
      if ($urandom_range(0, 1)) tone_q = -tone_q;
      noise_span = $urandom_range(0, 64);
      len = $urandom_range(20, 120) + int'(win);
      for (j = 0; j < len; j++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) style = STYLE_TONE;
        else if (pick < 8) style = STYLE_CORNER;
        else if (pick < 9) style = STYLE_SATURATE;
        else style = STYLE_NOISE;
        last = (j == len - 1) || ($urandom_range(0, 49) == 0);
        send_group(random_group(style, last), 1'b0, 1'b0, '0);
        random_groups++;
      end
    end

    settle();
    $display("Run covered %0d sample groups and %0d event beats over %0d register writes,",
             groups_accepted, events_checked, settings_applied);
    $display("with windows of one to a few hundred groups under sender gaps and receiver stalls.");
    if (mismatches == 0) begin
      $display("iq_tone_energy_detector: match");
    end else begin
      $display("iq_tone_energy_detector: mismatch");
    end
    $finish;
  end

endmodule
